/* rtl/core/accent_folding_substring_matcher_unit_assert.svh */
// Assertion macros for the accent-folding substring matcher.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef ACCENT_FOLDING_SUBSTRING_MATCHER_UNIT_ASSERT_SVH
`define ACCENT_FOLDING_SUBSTRING_MATCHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFSM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afsm assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AFSM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afsm assertion failed");

`endif

/* rtl/core/afsm_pkg.sv */
// Shared types, constants and the byte folding function of the matcher.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package afsm_pkg;

    localparam int PATTERN_MAX_DEFAULT   = 8;
    localparam int POSITION_BITS_DEFAULT = 16;

    localparam int PATTERN_BYTES_W = 64;
    localparam int LEN_REG_W       = 4;
    localparam int CFG_INDEX_W     = 1;
    localparam int POS_OUT_W       = 16;
    localparam int COUNT_W         = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'b1;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    localparam logic [7:0] BYTE_LEAD = 8'hC3;

    // One queue entry carries every result of one accepted byte.
    typedef struct packed {
        logic                 hit;
        logic                 eot;
        logic [POS_OUT_W-1:0] start_pos;
        logic [POS_OUT_W-1:0] end_pos;
        logic [COUNT_W-1:0]   count;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        case (b) inside
            8'hA1, 8'hA3: r = 8'h61;
            8'hA9:        r = 8'h65;
            8'hAD:        r = 8'h69;
            8'hB3:        r = 8'h6F;
            8'hBA:        r = 8'h75;
            8'hA7:        r = 8'h63;
            default:      r = b;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/afsm_front.sv */
// Front end: configuration registers, byte folding, window, counters and match test.
// Depends on afsm_pkg; pushes one entry per byte that causes any result.
`timescale 1ns / 1ps

module afsm_front #(
    parameter int PATTERN_MAX   = afsm_pkg::PATTERN_MAX_DEFAULT,
    parameter int POSITION_BITS = afsm_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [afsm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [afsm_pkg::PATTERN_BYTES_W-1:0] cfg_data,
    input  logic                                 accept,
    input  logic [7:0]                           text_byte,
    input  logic                                 end_of_text,
    output logic                                 push,
    output afsm_pkg::entry_t                     push_entry
);
    import afsm_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_BYTES_W-1:0] pattern_bytes_reg;
    logic [LEN_REG_W-1:0]       pattern_length_reg;
    logic [7:0]                 window_reg [PATTERN_MAX];
    logic [7:0]                 window_next [PATTERN_MAX];
    logic [7:0]                 shifted [PATTERN_MAX];
    logic [POSITION_BITS-1:0]   pos_reg, pos_next, pos_inc;
    logic [LEN_W-1:0]           gap_reg, gap_next, gap_inc;
    logic [COUNT_W-1:0]         count_reg, count_next, count_hit;
    logic [LEN_W-1:0]           eff_len, len_m1;
    logic [PATTERN_MAX-1:0]     hit_by_len;
    logic                       keep, hit;
    logic [POS_OUT_W-1:0]       end16;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pattern_bytes_reg  <= '0;
            pattern_length_reg <= LEN_REG_W'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:  pattern_bytes_reg  <= cfg_data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_REG_W-1:0];
                default:            pattern_bytes_reg  <= pattern_bytes_reg;
            endcase
        end
    end

    always_comb begin
        if (pattern_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (pattern_length_reg > LEN_REG_W'(PATTERN_MAX))
        begin
            eff_len = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            eff_len = LEN_W'(pattern_length_reg);
        end
        len_m1 = eff_len - LEN_W'(1);
    end

    assign keep = (text_byte != BYTE_LEAD);

    always_comb begin
        shifted[0] = fold_byte(text_byte);
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            shifted[i] = window_reg[i-1];
        end
    end

    // One candidate result per possible pattern length, each with fixed taps;
    // the active length then selects among them.
    always_comb begin
        for (int l = 0; l < PATTERN_MAX; l++)
        begin
            hit_by_len[l] = 1'b1;
            for (int i = 0; i <= l; i++)
            begin
                if (shifted[l-i] != pattern_bytes_reg[8*i +: 8])
                begin
                    hit_by_len[l] = 1'b0;
                end
            end
        end
    end

    assign pos_inc = (pos_reg != '1) ? pos_reg + POSITION_BITS'(1) : pos_reg;
    assign gap_inc = (gap_reg < LEN_W'(PATTERN_MAX)) ? gap_reg + LEN_W'(1) : gap_reg;
    assign hit     = keep && (gap_inc >= eff_len) && hit_by_len[IDX_W'(len_m1)];
    assign count_hit = (hit && count_reg != '1) ? count_reg + COUNT_W'(1) : count_reg;

    always_comb begin
        window_next = window_reg;
        pos_next    = pos_reg;
        gap_next    = gap_reg;
        count_next  = count_hit;
        if (keep)
        begin
            window_next = shifted;
            pos_next    = pos_inc;
            gap_next    = hit ? '0 : gap_inc;
        end
        if (end_of_text)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                window_next[i] = '0;
            end
            pos_next   = '0;
            gap_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                window_reg[i] <= '0;
            end
            pos_reg   <= '0;
            gap_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            pos_reg    <= pos_next;
            gap_reg    <= gap_next;
            count_reg  <= count_next;
        end
    end

    assign end16 = POS_OUT_W'(pos_inc);

    always_comb begin
        push                 = accept && (hit || end_of_text);
        push_entry.hit       = hit;
        push_entry.eot       = end_of_text;
        push_entry.end_pos   = end16;
        push_entry.start_pos = end16 - POS_OUT_W'(len_m1);
        push_entry.count     = count_hit;
    end

endmodule

/* rtl/core/afsm_queue.sv */
// Short queue between the front and back ends of the matcher.
// Depends on afsm_pkg for the entry and status types.
`timescale 1ns / 1ps

module afsm_queue #(
    parameter int DEPTH = afsm_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  afsm_pkg::entry_t       push_entry,
    input  logic                   pop,
    output afsm_pkg::entry_t       head,
    output afsm_pkg::queue_status_t status
);
    import afsm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0]   level_reg, level_next;

    always_ff @(posedge clk) begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_comb begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            level_reg <= level_next;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (level_reg == LVL_W'(DEPTH));
    assign status.empty = (level_reg == '0);

endmodule

/* rtl/core/afsm_back.sv */
// Back end: turns queue entries into result transactions in an output register.
// Depends on afsm_pkg; an entry with a match and an end of text gives two results.
`timescale 1ns / 1ps

module afsm_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  afsm_pkg::entry_t               head,
    input  afsm_pkg::queue_status_t        status,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           kind,
    output logic [afsm_pkg::POS_OUT_W-1:0] start_position,
    output logic [afsm_pkg::POS_OUT_W-1:0] end_position,
    output logic [afsm_pkg::COUNT_W-1:0]   match_count,
    output logic                           last
);
    import afsm_pkg::*;

    logic                 valid_reg;
    logic                 second_reg, second_next;
    logic                 kind_reg, last_reg;
    logic [POS_OUT_W-1:0] start_reg, end_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 load, emit_match;

    assign load       = (!valid_reg || out_ready) && !status.empty;
    // The match result of an entry always goes out before its count result.
    assign emit_match = head.hit && !second_reg;

    always_comb begin
        pop         = 1'b0;
        second_next = second_reg;
        if (load)
        begin
            if (emit_match && head.eot)
            begin
                second_next = 1'b1;
            end
            else
            begin
                pop         = 1'b1;
                second_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load)
        begin
            if (emit_match)
            begin
                kind_reg  <= KIND_MATCH;
                start_reg <= head.start_pos;
                end_reg   <= head.end_pos;
                count_reg <= '0;
                last_reg  <= !head.eot;
            end
            else
            begin
                kind_reg  <= KIND_COUNT;
                start_reg <= '0;
                end_reg   <= '0;
                count_reg <= head.count;
                last_reg  <= 1'b1;
            end
        end
    end

    assign out_valid      = valid_reg;
    assign kind           = kind_reg;
    assign start_position = start_reg;
    assign end_position   = end_reg;
    assign match_count    = count_reg;
    assign last           = last_reg;

endmodule

/* rtl/core/accent_folding_substring_matcher_unit.sv */
// The matcher takes one text byte per clock cycle while its internal queue has room,
// and delivers one result per cycle while the consumer is ready. Each byte is folded,
// shifted into the window and compared against the pattern in the cycle it is
// accepted. A byte that both completes a match and ends the text yields two
// results, so the back end sends two transactions for it; the four-entry queue between
// the front and back ends absorbs that and short output stalls. Configuration
// writes take effect on the next accepted byte.
`timescale 1ns / 1ps
`include "accent_folding_substring_matcher_unit_assert.svh"

module accent_folding_substring_matcher_unit #(
    parameter int PATTERN_MAX   = afsm_pkg::PATTERN_MAX_DEFAULT,
    parameter int POSITION_BITS = afsm_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [afsm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [afsm_pkg::PATTERN_BYTES_W-1:0] cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           text_byte,
    input  logic                                 end_of_text,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 kind,
    output logic [afsm_pkg::POS_OUT_W-1:0]       start_position,
    output logic [afsm_pkg::POS_OUT_W-1:0]       end_position,
    output logic [afsm_pkg::COUNT_W-1:0]         match_count,
    output logic                                 last
);
    import afsm_pkg::*;

    logic          accept;
    logic          push, pop;
    entry_t        push_entry, head;
    queue_status_t q_status;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    afsm_front #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .push         (push),
        .push_entry   (push_entry)
    );

    afsm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    afsm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .status         (q_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .start_position (start_position),
        .end_position   (end_position),
        .match_count    (match_count),
        .last           (last)
    );

    `AFSM_ASSERT_NOW(a_count_is_last, out_valid && kind == KIND_COUNT, last)
    `AFSM_ASSERT_NOW(a_count_no_pos, out_valid && kind == KIND_COUNT,
                     start_position == '0 && end_position == '0)
    `AFSM_ASSERT_NOW(a_match_no_count, out_valid && kind == KIND_MATCH, match_count == '0)
    `AFSM_ASSERT_NOW(a_pop_needs_entry, pop, !q_status.empty)
    `AFSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                      out_valid && $stable(kind) && $stable(start_position) &&
                      $stable(end_position) && $stable(match_count) && $stable(last))

endmodule

/* test/afsm_match_checker.sv */
// Scoreboard for the accent-folding substring matcher: tracks register writes, predicts
// the result transactions of every accepted text byte and compares them in order.
// Depends on afsm_pkg; also holds afsm_tb_pkg, the accent byte codes shared with tb_top.
`timescale 1ns / 1ps

package afsm_tb_pkg;

    // Second bytes of the two-byte accented letters that the block folds.
    localparam logic [7:0] ACUTE_A   = 8'hA1;
    localparam logic [7:0] TILDE_A   = 8'hA3;
    localparam logic [7:0] ACUTE_E   = 8'hA9;
    localparam logic [7:0] ACUTE_I   = 8'hAD;
    localparam logic [7:0] ACUTE_O   = 8'hB3;
    localparam logic [7:0] ACUTE_U   = 8'hBA;
    localparam logic [7:0] CEDILLA_C = 8'hA7;

endpackage

module afsm_match_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [afsm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [afsm_pkg::PATTERN_BYTES_W-1:0] cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic [7:0]                           text_byte,
    input  logic                                 end_of_text,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 kind,
    input  logic [afsm_pkg::POS_OUT_W-1:0]       start_position,
    input  logic [afsm_pkg::POS_OUT_W-1:0]       end_position,
    input  logic [afsm_pkg::COUNT_W-1:0]         match_count,
    input  logic                                 last,
    output int                                   failures,
    output int                                   outstanding
);
    import afsm_pkg::*;
    import afsm_tb_pkg::*;

    localparam int WINDOW_DEPTH = 8;
    localparam int REPORT_LIMIT = 10;
    localparam logic [POS_OUT_W-1:0] POSITION_TOP = '1;
    localparam logic [COUNT_W-1:0]   COUNT_TOP    = '1;

    typedef struct packed {
        logic                 kind;
        logic [POS_OUT_W-1:0] start_pos;
        logic [POS_OUT_W-1:0] end_pos;
        logic [COUNT_W-1:0]   count;
        logic                 last;
    } text_result_t;

    logic [PATTERN_BYTES_W-1:0] search_word;
    logic [LEN_REG_W-1:0]       search_len_reg;
    logic [7:0]                 recent_chars [WINDOW_DEPTH];
    logic [POS_OUT_W-1:0]       char_position;
    int                         chars_since_match;
    logic [COUNT_W-1:0]         hits_in_text;
    text_result_t               expected_results [$];
    int                         mismatch_total;

    function automatic logic [7:0] fold_accent(input logic [7:0] b);
        case (b)
            ACUTE_A, TILDE_A: return "a";
            ACUTE_E:          return "e";
            ACUTE_I:          return "i";
            ACUTE_O:          return "o";
            ACUTE_U:          return "u";
            CEDILLA_C:        return "c";
            default:          return b;
        endcase
    endfunction

    function automatic void clear_text_state();
        for (int i = 0; i < WINDOW_DEPTH; i++)
            recent_chars[i] = 8'h00;
        char_position = '0;
        chars_since_match = 0;
        hits_in_text = '0;
    endfunction

    // Works out the results of one accepted byte and queues them in output order.
    function automatic void predict_byte(input logic [7:0] b, input logic eot);
        int           span;
        bit           hit;
        text_result_t match_r;
        text_result_t total_r;
        match_r = '0;
        total_r = '0;
        if (b != BYTE_LEAD)
        begin
            span = (search_len_reg == 0) ? 1 :
                   (search_len_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(search_len_reg);
            for (int i = WINDOW_DEPTH - 1; i > 0; i--)
                recent_chars[i] = recent_chars[i - 1];
            recent_chars[0] = fold_accent(b);
            if (char_position != POSITION_TOP)
                char_position++;
            if (chars_since_match < WINDOW_DEPTH)
                chars_since_match++;
            // A new match may start only after a full pattern length of fresh characters.
            hit = chars_since_match >= span;
            for (int i = 0; i < span; i++)
                if (recent_chars[span - 1 - i] != search_word[8 * i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                chars_since_match = 0;
                if (hits_in_text != COUNT_TOP)
                    hits_in_text++;
                match_r.kind = KIND_MATCH;
                match_r.start_pos = char_position - POS_OUT_W'(span - 1);
                match_r.end_pos = char_position;
                match_r.last = !eot;
                expected_results.push_back(match_r);
            end
        end
        if (eot)
        begin
            total_r.kind = KIND_COUNT;
            total_r.count = hits_in_text;
            total_r.last = 1'b1;
            expected_results.push_back(total_r);
            clear_text_state();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        text_result_t got;
        text_result_t want;
        if (!rst_n)
        begin
            search_word = '0;
            search_len_reg = LEN_REG_W'(1);
            clear_text_state();
            expected_results.delete();
            mismatch_total = 0;
            failures <= 0;
            outstanding <= 0;
        end
        else
        begin
            // A byte taken together with a register write still sees the old setting.
            if (in_valid && in_ready)
                predict_byte(text_byte, end_of_text);
            if (cfg_write_en)
            begin
                if (cfg_index == REG_PATTERN_BYTES)
                    search_word = cfg_data;
                else if (cfg_index == REG_PATTERN_LENGTH)
                    search_len_reg = cfg_data[LEN_REG_W-1:0];
            end
            if (out_valid && out_ready)
            begin
                got = {kind, start_position, end_position, match_count, last};
                if (expected_results.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT)
                        $display("unexpected result transaction: kind=%0d start=%0d end=%0d count=%0d last=%0d",
                                 got.kind, got.start_pos, got.end_pos, got.count, got.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.start_pos !== want.start_pos ||
                        got.end_pos !== want.end_pos || got.count !== want.count ||
                        got.last !== want.last)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT)
                            $display("result mismatch: expected kind=%0d start=%0d end=%0d count=%0d last=%0d, got kind=%0d start=%0d end=%0d count=%0d last=%0d",
                                     want.kind, want.start_pos, want.end_pos, want.count,
                                     want.last, got.kind, got.start_pos, got.end_pos,
                                     got.count, got.last);
                    end
                end
            end
            outstanding <= expected_results.size();
            failures <= mismatch_total;
        end
    end

endmodule

/* test/tb_top.sv */
// Top of the matcher testbench: clock, reset, register writes, text stimulus and the
// randomly stalling result consumer. Needs afsm_pkg, the block itself and the checker
// file, which also provides afsm_tb_pkg; the checker decides every result.
`timescale 1ns / 1ps

module tb_top;
    import afsm_pkg::*;
    import afsm_tb_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int BURST_ITEMS    = 40;
    localparam int HOLD_OFF       = 400;
    localparam logic [7:0] LETTERS [7] = '{"a", "b", "c", "e", "i", "o", "u"};

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_write_en;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [PATTERN_BYTES_W-1:0] cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [7:0]                 text_byte;
    logic                       end_of_text;
    logic                       out_valid;
    logic                       out_ready;
    logic                       kind;
    logic [POS_OUT_W-1:0]       start_position;
    logic [POS_OUT_W-1:0]       end_position;
    logic [COUNT_W-1:0]         match_count;
    logic                       last;
    int                         failures;
    int                         outstanding;

    int         cycle_count = 0;
    int         random_items = 0;
    bit         tx_gaps_on = 1'b1;
    bit         rx_gaps_on = 1'b1;
    bit         hold_request = 1'b0;
    logic [7:0] text_q [$];

    always #10 clk = ~clk;

    accent_folding_substring_matcher_unit uut (.*);

    afsm_match_checker scoreboard (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result consumer: a random wait before each transaction, or one long hold-off on request.
    initial
    begin
        int wait_cycles;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            wait_cycles = hold_request ? HOLD_OFF : (rx_gaps_on ? int'($urandom_range(0, 19)) : 0);
            hold_request = 1'b0;
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = tx_gaps_on ? int'($urandom_range(0, 19)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_byte <= b;
        end_of_text <= eot;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Called right after the last accepted transaction; the block is idle on return.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(input logic [63:0] pattern_word, input logic [63:0] length_word);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_PATTERN_BYTES;
        cfg_data <= pattern_word;
        @(posedge clk);
        cfg_index <= REG_PATTERN_LENGTH;
        cfg_data <= length_word;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic send_text(input bit with_end);
        for (int k = 0; k < text_q.size(); k++)
        begin
            send_byte(text_q[k], with_end && (k == text_q.size() - 1));
            random_items++;
        end
        text_q.delete();
    endtask

    // Appends one character, spelled plain, as a lone accent byte or as a two-byte accent.
    function automatic void add_char(input logic [7:0] c);
        logic [7:0] accent;
        int         form;
        case (c)
            "a":     accent = $urandom_range(0, 1) ? ACUTE_A : TILDE_A;
            "c":     accent = CEDILLA_C;
            "e":     accent = ACUTE_E;
            "i":     accent = ACUTE_I;
            "o":     accent = ACUTE_O;
            "u":     accent = ACUTE_U;
            default: accent = c;
        endcase
        form = (accent == c) ? 2 : int'($urandom_range(0, 2));
        if ($urandom_range(0, 15) == 0)
            text_q.push_back(BYTE_LEAD);
        case (form)
            0:
            begin
                text_q.push_back(BYTE_LEAD);
                text_q.push_back(accent);
            end
            1:       text_q.push_back(accent);
            default: text_q.push_back(c);
        endcase
    endfunction

    function automatic logic [7:0] pattern_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return LETTERS[$urandom_range(0, 6)];
        else if (r < 18)
            return 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_phase(input int index);
        logic [LEN_REG_W-1:0] len_reg;
        logic [63:0]          pat;
        logic [63:0]          len_word;
        int                   span;
        int                   texts;
        int                   units;
        int                   r;
        int                   cut;
        int                   pick;
        bit                   open_end;
        case (index)
            0:       len_reg = 4'd0;
            1:       len_reg = 4'd15;
            2:       len_reg = 4'd8;
            3:       len_reg = 4'd1;
            default: len_reg = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) :
                                                             4'($urandom_range(1, 8));
        endcase
        span = (len_reg == 0) ? 1 : (len_reg > 8) ? 8 : int'(len_reg);
        pat = {$urandom, $urandom};
        for (int i = 0; i < span; i++)
            pat[8 * i +: 8] = pattern_char();
        len_word = {$urandom, $urandom};
        len_word[LEN_REG_W-1:0] = len_reg;
        write_config(pat, len_word);
        tx_gaps_on = $urandom_range(0, 3) != 0;
        rx_gaps_on = $urandom_range(0, 3) != 0;
        texts = $urandom_range(1, 6);
        for (int t = 0; t < texts; t++)
        begin
            units = $urandom_range(1, 25);
            for (int u = 0; u < units; u++)
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                begin
                    for (int i = 0; i < span; i++)
                        add_char(pat[8 * i +: 8]);
                end
                else if (r < 8)
                begin
                    pick = $urandom_range(0, span - 1);
                    add_char($urandom_range(0, 1) ? pat[8 * pick +: 8] :
                                                    LETTERS[$urandom_range(0, 6)]);
                end
                else if (r == 8)
                    text_q.push_back(8'($urandom_range(0, 255)));
                else
                begin
                    // A pattern prefix, which may also run to the full pattern.
                    cut = $urandom_range(1, span);
                    for (int i = 0; i < cut; i++)
                        add_char(pat[8 * i +: 8]);
                end
            end
            if ($urandom_range(0, 7) == 0)
                text_q.push_back(BYTE_LEAD);
            // The last text of a phase may stay open, so the next setting applies mid-text.
            open_end = (t == texts - 1) && ($urandom_range(0, 3) == 0);
            send_text(!open_end);
        end
        settle();
    endtask

    // Every character matches while the consumer holds off, so the block fills and stalls its input.
    task automatic run_backpressure();
        logic [63:0] pat;
        pat = {$urandom, $urandom};
        pat[7:0] = "a";
        write_config(pat, 64'd1);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b1;
        hold_request = 1'b1;
        for (int k = 0; k < 80; k++)
            add_char("a");
        send_text(1'b1);
        settle();
    endtask

    initial
    begin
        logic [63:0] pat;
        int          phase;
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= REG_PATTERN_BYTES;
        cfg_data <= '0;
        in_valid <= 1'b0;
        text_byte <= 8'h00;
        end_of_text <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting searches for one zero byte; a match on the final byte comes before the count.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(BYTE_LEAD, 1'b1);
        send_byte(BYTE_LEAD, 1'b1);
        settle();

        pat = '0;
        pat[31:0] = {"e", "f", "a", "c"};
        write_config(pat, 64'd4);
        send_byte("c", 1'b0);
        send_byte(BYTE_LEAD, 1'b0);
        send_byte(ACUTE_A, 1'b0);
        send_byte("f", 1'b0);
        send_byte(BYTE_LEAD, 1'b0);
        send_byte(ACUTE_E, 1'b0);
        send_byte(CEDILLA_C, 1'b0);
        send_byte(TILDE_A, 1'b0);
        send_byte("f", 1'b0);
        send_byte(ACUTE_E, 1'b1);
        settle();

        // All-ones pattern with an oversized length register.
        write_config('1, 64'd15);
        for (int k = 0; k < 8; k++)
            send_byte(8'hFF, k == 7);
        settle();

        // A back-to-back burst to a consumer that is always ready; the text stays open
        // into the next setting.
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        pat = {$urandom, $urandom};
        pat[7:0] = "a";
        write_config(pat, 64'd1);
        for (int k = 0; k < BURST_ITEMS; k++)
            send_byte("a", 1'b0);
        settle();
        pat[15:0] = {"b", "a"};
        write_config(pat, 64'd2);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b1);
        settle();

        run_backpressure();

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            run_phase(phase);
            phase++;
        end

        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
